// File: src/queue_with_middle_insert_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the middle-insert queue.
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef QUEUE_WITH_MIDDLE_INSERT_CORE_ASSERT_SVH
`define QUEUE_WITH_MIDDLE_INSERT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QWMI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define QWMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue assertion failed");

`endif

// File: src/qwmi_pkg.sv
// ----------------------------------------------------------------------------
// qwmi_pkg
// Types and constants shared by the middle-insert queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qwmi_pkg;

    // Default number of entry cells.
    localparam int DEPTH_DEF = 32;

    // Width of one stored entry.
    localparam int DATA_W = 32;

    // Item action codes.
    typedef enum logic [1:0] {
        ACT_PUSH_TAIL = 2'd0,
        ACT_PUSH_MID  = 2'd1,
        ACT_POP       = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic write;   // a push writes the new value at the given position
        logic insert;  // cells past the position take their left neighbor
        logic pop;     // every cell takes its right neighbor
    } cell_ctl_t;

endpackage

// File: src/queue_with_middle_insert_core.sv
// ----------------------------------------------------------------------------
// queue_with_middle_insert_core
// The result item is registered and appears in the cycle after its item is accepted.
// One item per cycle while the result is not held by out_stall; every cell of
// the row updates in parallel for push back, middle insert and pop.
// Reset clears the count and the result valid; entry cells are not reset.
// Bounded ordered queue with push back, push middle and pop front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module queue_with_middle_insert_core #(
    parameter int DEPTH = qwmi_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            popped_value,
    output logic [1:0]                    status
);

    localparam int CW = $clog2(DEPTH + 1);

    qwmi_pkg::cell_ctl_t           ctl;
    logic [CW-1:0]                 pos;
    logic [qwmi_pkg::DATA_W-1:0]   cell_data [DEPTH];
    logic [qwmi_pkg::DATA_W-1:0]   popped_u;

    // Count, command decode and result register.
    qwmi_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (action),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .head_data    (cell_data[0]),
        .ctl          (ctl),
        .pos          (pos),
        .popped_value (popped_u),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

    assign popped_value = signed'(popped_u);

    // Row of entry cells, head at index zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [qwmi_pkg::DATA_W-1:0] left_d;
        logic [qwmi_pkg::DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        qwmi_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .value      (unsigned'(value)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

endmodule

// File: src/qwmi_cell.sv
// ----------------------------------------------------------------------------
// qwmi_cell
// One entry cell of the queue row: holds a value and updates it from the new
// value or from its left or right neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qwmi_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                          clk,
    input  qwmi_pkg::cell_ctl_t           ctl,
    input  logic [CW-1:0]                 pos,
    input  logic [qwmi_pkg::DATA_W-1:0]   value,
    input  logic [qwmi_pkg::DATA_W-1:0]   left_data,
    input  logic [qwmi_pkg::DATA_W-1:0]   right_data,
    output logic [qwmi_pkg::DATA_W-1:0]   data
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [qwmi_pkg::DATA_W-1:0] data_reg;
    logic [qwmi_pkg::DATA_W-1:0] data_next;

    // Select the new cell content for this cycle's command.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.pop)
        begin
            data_next = right_data;
        end
        else if (ctl.write)
        begin
            if (pos == IDX_C)
            begin
                data_next = value;
            end
            else if (ctl.insert && (IDX_C > pos))
            begin
                data_next = left_data;
            end
        end
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: src/qwmi_ctrl.sv
// ----------------------------------------------------------------------------
// qwmi_ctrl
// Queue control: occupancy count, command decode for the cell row, and the
// registered result item with its handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qwmi_ctrl #(
    parameter int DEPTH = qwmi_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    action,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [qwmi_pkg::DATA_W-1:0]   head_data,
    output qwmi_pkg::cell_ctl_t           ctl,
    output logic [CW-1:0]                 pos,
    output logic [qwmi_pkg::DATA_W-1:0]   popped_value,
    output logic [1:0]                    status,
    output logic                          out_valid,
    input  logic                          out_stall
);

    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [qwmi_pkg::DATA_W-1:0]   popped_reg;
    logic [qwmi_pkg::DATA_W-1:0]   popped_next;
    qwmi_pkg::status_t             status_reg;
    qwmi_pkg::status_t             status_next;
    logic                          accept;
    logic                          full;
    logic                          empty;
    logic [CW:0]                   count_inc;
    logic [CW-1:0]                 half_pos;
    qwmi_pkg::action_t             act;

    // Input is held only while a finished result waits downstream.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == FULL_C);
    assign empty    = (count_reg == '0);
    assign act      = qwmi_pkg::action_t'(action);

    // Middle position is ceil(count / 2).
    assign count_inc = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};
    assign half_pos  = count_inc[CW:1];
    assign pos       = (act == qwmi_pkg::ACT_PUSH_MID) ? half_pos : count_reg;

    // Decode the accepted item into a cell command and a result.
    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = qwmi_pkg::ST_OK;
        popped_next = '0;
        if (accept)
        begin
            unique case (act)
                qwmi_pkg::ACT_PUSH_TAIL,
                qwmi_pkg::ACT_PUSH_MID:
                begin
                    if (full)
                    begin
                        status_next = qwmi_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.write  = 1'b1;
                        ctl.insert = (act == qwmi_pkg::ACT_PUSH_MID);
                        count_next = count_reg + CW'(1);
                    end
                end
                qwmi_pkg::ACT_POP:
                begin
                    if (empty)
                    begin
                        status_next = qwmi_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.pop     = 1'b1;
                        popped_next = head_data;
                        count_next  = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = qwmi_pkg::ST_OK;
                end
            endcase
        end
    end

    // Result valid: set by an accepted item, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;

endmodule

// File: src/qwmi_checker.sv
// ----------------------------------------------------------------------------
// qwmi_checker
// Port-level checks for the middle-insert queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "queue_with_middle_insert_core_assert.svh"

module qwmi_checker #(
    parameter int DEPTH = qwmi_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         action,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] popped_value,
    input  logic [1:0]         status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    logic          in_acc;
    logic          is_push;
    logic          is_pop;
    logic [CW-1:0] shadow_reg;
    logic [CW-1:0] shadow_next;
    logic          held;
    logic          pop_on_empty;
    logic          push_on_full;
    logic          empty_rep;
    logic          full_rep;

    assign in_acc  = in_valid && !in_stall;
    assign is_push = (action == qwmi_pkg::ACT_PUSH_TAIL) ||
                     (action == qwmi_pkg::ACT_PUSH_MID);
    assign is_pop  = (action == qwmi_pkg::ACT_POP);

    // Occupancy as seen from the input port.
    always_comb
    begin
        shadow_next = shadow_reg;
        if (in_acc)
        begin
            if (is_push && (shadow_reg != FULL_C))
            begin
                shadow_next = shadow_reg + CW'(1);
            end
            else if (is_pop && (shadow_reg != '0))
            begin
                shadow_next = shadow_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= '0;
        end
        else
        begin
            shadow_reg <= shadow_next;
        end
    end

    // Conditions and expected results used by the checks below.
    assign held         = out_valid && out_stall;
    assign pop_on_empty = in_acc && is_pop && (shadow_reg == '0);
    assign push_on_full = in_acc && is_push && (shadow_reg == FULL_C);
    assign empty_rep    = (status == qwmi_pkg::ST_EMPTY) && (popped_value == '0);
    assign full_rep     = (status == qwmi_pkg::ST_FULL) && (popped_value == '0);

    // A stalled result holds.
    `QWMI_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable({popped_value, status}))

    // Every accepted item produces a result in the next cycle.
    `QWMI_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_valid)

    // A pop with nothing stored reports empty.
    `QWMI_ASSERT_NEXT(a_pop_empty, clk, rst_n, pop_on_empty, empty_rep)

    // A push into a full queue reports full.
    `QWMI_ASSERT_NEXT(a_push_full, clk, rst_n, push_on_full, full_rep)

endmodule

bind queue_with_middle_insert_core qwmi_checker #(.DEPTH(DEPTH)) u_qwmi_checker (.*);

// File: tb/tb_queue_with_middle_insert_core.sv
// ----------------------------------------------------------------------------
// tb_queue_with_middle_insert_core
// Self-checking bench for the bounded queue with push back, middle insert
// and pop front. A mirror of the queue predicts one result per accepted item
// and checks each accepted result in order. Directed items cover the value
// extremes and the empty case. Random items follow, in biased segments and
// fill-and-drain bursts that reach full, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_queue_with_middle_insert_core;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 10;
    localparam int QDEPTH         = qwmi_pkg::DEPTH_DEF;
    localparam int TOTAL_ITEMS    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // One result item: the value taken from the head and the status.
    typedef struct packed {
        logic [31:0]       popped;
        qwmi_pkg::status_t status;
    } queue_result_t;

    // Mirror of the queue contents and the results still owed by the block.
    class middle_queue_mirror;
        logic [31:0]   cells[$];
        queue_result_t pending_results[$];
        int unsigned   depth;
        int unsigned   items_noted;
        int unsigned   mid_inserts;
        int unsigned   full_refusals;
        int unsigned   empty_pops;
        int unsigned   results_checked;
        int unsigned   mismatches;

        function new(int unsigned qdepth);
            depth = qdepth;
        endfunction

        // Apply one accepted item to the mirror and queue its result.
        function void note_item(qwmi_pkg::action_t act, logic [31:0] val);
            queue_result_t res;
            res.popped = '0;
            res.status = qwmi_pkg::ST_OK;
            items_noted++;
            case (act)
                qwmi_pkg::ACT_PUSH_TAIL, qwmi_pkg::ACT_PUSH_MID:
                begin
                    if (cells.size() >= depth)
                    begin
                        res.status = qwmi_pkg::ST_FULL;
                        full_refusals++;
                    end
                    else if (act == qwmi_pkg::ACT_PUSH_TAIL)
                    begin
                        cells.insert(cells.size(), val);
                    end
                    else
                    begin
                        // The new value lands at ceil(count/2) from the head.
                        cells.insert((cells.size() + 1) / 2, val);
                        mid_inserts++;
                    end
                end
                qwmi_pkg::ACT_POP:
                begin
                    if (cells.size() == 0)
                    begin
                        res.status = qwmi_pkg::ST_EMPTY;
                        empty_pops++;
                    end
                    else
                    begin
                        res.popped = cells.pop_front();
                    end
                end
                default:
                begin
                    // The unused code leaves the queue alone and reports ok.
                end
            endcase
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: mismatch on result %0d: %s expected %h got %h",
                         $time, results_checked, what, want, got);
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(logic [31:0] got_value, logic [1:0] got_status);
            queue_result_t want;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                flag("result with no item outstanding, popped_value", '0, got_value);
                return;
            end
            want = pending_results.pop_front();
            if (got_value !== want.popped)
                flag("popped_value", want.popped, got_value);
            if (got_status !== want.status)
                flag("status", 32'(want.status), 32'(got_status));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        action = qwmi_pkg::ACT_PUSH_TAIL;
    logic signed [31:0] value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [31:0] popped_value;
    logic [1:0]        status;

    middle_queue_mirror mirror = new(QDEPTH);

    bit          in_calm  = 1'b0;
    bit          out_calm = 1'b0;
    int unsigned items_sent = 0;

    queue_with_middle_insert_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Number of idle cycles before the next item; none in a calm stretch.
    function automatic int draw_idle(bit calm);
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Extremes show up often; the rest are full 32-bit random values.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic qwmi_pkg::action_t random_push();
        return ($urandom_range(0, 1) != 0) ? qwmi_pkg::ACT_PUSH_MID
                                           : qwmi_pkg::ACT_PUSH_TAIL;
    endfunction

    function automatic qwmi_pkg::action_t pick_action(int unsigned push_pct);
        if ($urandom_range(0, 99) < 3)
            return qwmi_pkg::ACT_NONE;
        if ($urandom_range(0, 99) < push_pct)
            return random_push();
        return qwmi_pkg::ACT_POP;
    endfunction

    // Present one item and hold it until the block takes it. Called at a
    // rising edge; returns at the rising edge where the item was accepted.
    task automatic send_item(qwmi_pkg::action_t act, logic [31:0] val);
        int gap;
        gap = draw_idle(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        do
            @(negedge clk);
        while (in_stall !== 1'b0);
        mirror.note_item(act, val);
        @(posedge clk);
        if (act != qwmi_pkg::ACT_NONE)
            items_sent++;
    endtask

    // Fill the queue, push past full, then drain it and pop once more.
    task automatic run_fill_drain();
        int extra;
        extra = $urandom_range(1, 3);
        while (mirror.cells.size() < QDEPTH)
            send_item(random_push(), rand_value());
        repeat (extra) send_item(random_push(), rand_value());
        send_item(qwmi_pkg::ACT_NONE, rand_value());
        while (mirror.cells.size() > 0)
            send_item(qwmi_pkg::ACT_POP, rand_value());
        send_item(qwmi_pkg::ACT_POP, rand_value());
    endtask

    // Result side: check at mid-cycle, then set the stall for the next cycle.
    initial
    begin
        int stall_left;
        bit taken;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            taken = rst_n && out_valid && !out_stall;
            if (taken)
                mirror.check_result(popped_value, status);
            @(posedge clk);
            if (taken)
                stall_left = draw_idle(out_calm);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Watchdog: give up after a long run of cycles with no item moving.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_queue_with_middle_insert_core: FAIL");
        $finish;
    end

    // Main sequence: reset, directed items, random segments, drain, verdict.
    initial
    begin
        int seg_len;
        int unsigned push_pct;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: pop, unused code, middle insert as the only entry.
        send_item(qwmi_pkg::ACT_POP, 32'h1234_5678);
        send_item(qwmi_pkg::ACT_NONE, 32'hffff_ffff);
        send_item(qwmi_pkg::ACT_PUSH_MID, 32'h8000_0000);
        send_item(qwmi_pkg::ACT_POP, 32'h0);
        send_item(qwmi_pkg::ACT_POP, 32'h0);

        // Build a short queue with inserts at both even and odd counts.
        send_item(qwmi_pkg::ACT_PUSH_TAIL, 32'h7fff_ffff);
        send_item(qwmi_pkg::ACT_PUSH_TAIL, 32'h0000_0000);
        send_item(qwmi_pkg::ACT_PUSH_MID, 32'hffff_ffff);
        send_item(qwmi_pkg::ACT_PUSH_MID, 32'haaaa_aaaa);
        send_item(qwmi_pkg::ACT_PUSH_TAIL, 32'h5555_5555);
        send_item(qwmi_pkg::ACT_PUSH_MID, 32'h0000_0001);
        send_item(qwmi_pkg::ACT_NONE, 32'h0);
        repeat (6) send_item(qwmi_pkg::ACT_POP, 32'hffff_ffff);
        send_item(qwmi_pkg::ACT_POP, 32'h0);

        // Random part: each segment sets its own idling and push bias.
        while (items_sent < TOTAL_ITEMS)
        begin
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                run_fill_drain();
            end
            else
            begin
                seg_len = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    default: push_pct = 75;
                endcase
                repeat (seg_len) send_item(pick_action(push_pct), rand_value());
            end
        end
        in_valid <= 1'b0;

        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d middle inserts, %0d pushes refused as full,",
                 mirror.items_noted, mirror.mid_inserts, mirror.full_refusals);
        $display("%0d pops on an empty queue; %0d results checked, %0d mismatches.",
                 mirror.empty_pops, mirror.results_checked, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
            $display("tb_queue_with_middle_insert_core: PASS");
        else
            $display("tb_queue_with_middle_insert_core: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/qwmi_pkg.sv
src/qwmi_cell.sv
src/qwmi_ctrl.sv
src/queue_with_middle_insert_core.sv
src/qwmi_checker.sv
tb/tb_queue_with_middle_insert_core.sv
